FILE: src/srecord_to_flash_pages_macros.svh
// ----------------------------------------------------------------------------
// S-record page packer assertion macros
// Concurrent checks on clk_i with reset rst_ni; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef SRECORD_TO_FLASH_PAGES_MACROS_SVH
`define SRECORD_TO_FLASH_PAGES_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define S2FP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("s2fp check failed");
// Check that cons holds in the cycle after ante.
`define S2FP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("s2fp sequence check failed");
`else
`define S2FP_ASSERT(lbl, prop)
`define S2FP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/s2fp_pkg.sv
// ----------------------------------------------------------------------------
// s2fp_pkg
// Shared constants, types and the hex digit decoder of the S-record packer.
// ----------------------------------------------------------------------------
package s2fp_pkg;

  localparam int unsigned PAGE_BYTES = 512;
  localparam int unsigned MAX_PAGES  = 1024;

  localparam int unsigned ADDR_W = 24;
  localparam int unsigned FILL_W = $clog2(PAGE_BYTES + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_PAGES);

  localparam logic [7:0] LINE_END       = 8'd10;
  localparam logic [3:0] REC_KIND_S2    = 4'd2;
  localparam logic [7:0] COUNT_OVERHEAD = 8'd4;

  localparam logic [3:0] POS_KIND       = 4'd1;
  localparam logic [3:0] POS_COUNT_HI   = 4'd2;
  localparam logic [3:0] POS_COUNT_LO   = 4'd3;
  localparam logic [3:0] POS_ADDR_FIRST = 4'd4;
  localparam logic [3:0] POS_ADDR_LAST  = 4'd9;
  localparam logic [3:0] POS_DATA_START = 4'd10;

  typedef struct packed {
    logic [7:0]        data;
    logic [ADDR_W-1:0] addr;
  } s2fp_byte_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
    end else if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 8'd10);
    end
    return v;
  endfunction

endpackage

FILE: src/s2fp_parser.sv
// ----------------------------------------------------------------------------
// s2fp_parser
// Line parser: tracks field positions, decodes data bytes and registers each
// byte of a type 2 record with its address.
// ----------------------------------------------------------------------------
`include "srecord_to_flash_pages_macros.svh"

module s2fp_parser
  import s2fp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] char_in_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       ev_valid_o,
  output s2fp_byte_t ev_o,
  input  logic       ev_ready_i
);

  logic [3:0]        pos_q, pos_d;
  logic [3:0]        kind_q, kind_d;
  logic [7:0]        remain_q, remain_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [7:0]        index_q, index_d;
  logic [3:0]        high_q, high_d;
  logic              phase_q, phase_d;
  logic              in_data_q, in_data_d;
  logic              ev_valid_q, ev_valid_d;
  s2fp_byte_t        ev_q, ev_d;

  logic       accept;
  logic [3:0] v;
  logic [7:0] count;
  logic [3:0] pos_inc;

  assign in_ready_o = !ev_valid_q || ev_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign v          = hex_value(char_in_i);
  assign count      = {high_q, v};
  assign pos_inc    = pos_q + 4'd1;

  always_comb begin
    pos_d      = pos_q;
    kind_d     = kind_q;
    remain_d   = remain_q;
    addr_d     = addr_q;
    index_d    = index_q;
    high_d     = high_q;
    phase_d    = phase_q;
    in_data_d  = in_data_q;
    ev_valid_d = ev_valid_q && !ev_ready_i;
    ev_d       = ev_q;
    if (accept) begin
      if (char_in_i == LINE_END) begin
        pos_d     = '0;
        kind_d    = '0;
        remain_d  = '0;
        addr_d    = '0;
        index_d   = '0;
        high_d    = '0;
        phase_d   = 1'b0;
        in_data_d = 1'b0;
      end else if (!in_data_q) begin
        if (pos_q == POS_KIND) begin
          kind_d = v;
        end else if (pos_q == POS_COUNT_HI) begin
          high_d = v;
        end else if (pos_q == POS_COUNT_LO) begin
          remain_d = (count >= COUNT_OVERHEAD) ? count - COUNT_OVERHEAD : 8'd0;
        end else if (pos_q >= POS_ADDR_FIRST && pos_q <= POS_ADDR_LAST) begin
          addr_d = {addr_q[ADDR_W-5:0], v};
        end
        pos_d = pos_inc;
        if (pos_inc >= POS_DATA_START) begin
          pos_d     = POS_DATA_START;
          in_data_d = 1'b1;
          index_d   = '0;
          phase_d   = 1'b0;
        end
      end else if (remain_q != 8'd0) begin
        if (!phase_q) begin
          high_d  = v;
          phase_d = 1'b1;
        end else begin
          phase_d  = 1'b0;
          index_d  = index_q + 8'd1;
          remain_d = remain_q - 8'd1;
          if (kind_q == REC_KIND_S2) begin
            ev_valid_d = 1'b1;
            ev_d.data  = {high_q, v};
            ev_d.addr  = addr_q + ADDR_W'(index_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      kind_q     <= '0;
      remain_q   <= '0;
      addr_q     <= '0;
      index_q    <= '0;
      high_q     <= '0;
      phase_q    <= 1'b0;
      in_data_q  <= 1'b0;
      ev_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      kind_q     <= kind_d;
      remain_q   <= remain_d;
      addr_q     <= addr_d;
      index_q    <= index_d;
      high_q     <= high_d;
      phase_q    <= phase_d;
      in_data_q  <= in_data_d;
      ev_valid_q <= ev_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

  `S2FP_ASSERT(a_data_pos, !in_data_q || pos_q == POS_DATA_START)
  `S2FP_ASSERT_NEXT(a_line_clear, accept && char_in_i == LINE_END,
                    pos_q == 4'd0 && !in_data_q && !phase_q)

endmodule

FILE: src/s2fp_packer.sv
// ----------------------------------------------------------------------------
// s2fp_packer
// Page packer: opens pages on address gaps or full pages and registers each
// result with its page number and offset.
// ----------------------------------------------------------------------------
`include "srecord_to_flash_pages_macros.svh"

module s2fp_packer
  import s2fp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        ev_valid_i,
  input  s2fp_byte_t  ev_i,
  output logic        ev_ready_o,
  output logic [7:0]  data_byte_o,
  output logic [23:0] byte_address_o,
  output logic [9:0]  page_number_o,
  output logic [8:0]  page_offset_o,
  output logic        new_page_o,
  output logic        page_overflow_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  localparam logic [FILL_W-1:0] FillMax = FILL_W'(PAGE_BYTES);
  localparam logic [IDX_W-1:0]  IdxMax  = IDX_W'(MAX_PAGES - 1);

  logic [ADDR_W:0]   base_q, base_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              out_valid_q, out_valid_d;

  logic [7:0]        data_q;
  logic [ADDR_W-1:0] addr_q;
  logic [9:0]        number_q, number_d;
  logic [8:0]        offset_q, offset_d;
  logic              opened_q, opened_d;
  logic              ovf_q, ovf_d;

  logic              load;
  logic              contiguous;
  logic [FILL_W-1:0] fill_sel;
  logic [ADDR_W:0]   base_sel;

  assign ev_ready_o = !out_valid_q || out_ready_i;
  assign load       = ev_valid_i && ev_ready_o;
  assign contiguous = ({1'b0, ev_i.addr} == base_q) && (fill_q < FillMax);

  always_comb begin
    idx_d       = idx_q;
    opened_d    = 1'b0;
    ovf_d       = 1'b0;
    fill_sel    = fill_q;
    base_sel    = base_q;
    if (!contiguous) begin
      opened_d = 1'b1;
      fill_sel = '0;
      base_sel = {1'b0, ev_i.addr};
      if (idx_q >= IdxMax) begin
        idx_d = IdxMax;
        ovf_d = 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
    number_d    = 10'(idx_d);
    offset_d    = 9'(fill_sel);
    fill_d      = fill_sel + 1'b1;
    base_d      = base_sel + 1'b1;
    out_valid_d = load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      fill_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        base_q <= base_d;
        fill_q <= fill_d;
        idx_q  <= idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q   <= ev_i.data;
      addr_q   <= ev_i.addr;
      number_q <= number_d;
      offset_q <= offset_d;
      opened_q <= opened_d;
      ovf_q    <= ovf_d;
    end
  end

  assign data_byte_o     = data_q;
  assign byte_address_o  = addr_q;
  assign page_number_o   = number_q;
  assign page_offset_o   = offset_q;
  assign new_page_o      = opened_q;
  assign page_overflow_o = ovf_q;
  assign out_valid_o     = out_valid_q;

  `S2FP_ASSERT(a_fill_bound, fill_q <= FillMax && fill_q != '0 || idx_q == '0)
  `S2FP_ASSERT(a_ovf_opens, !out_valid_q || !ovf_q || opened_q)
  `S2FP_ASSERT_NEXT(a_page_step, load && !contiguous && idx_q < IdxMax,
                    idx_q == $past(idx_q) + 1'b1 && fill_q == FILL_W'(1))

endmodule

FILE: src/srecord_to_flash_pages.sv
// ----------------------------------------------------------------------------
// srecord_to_flash_pages
// Type 2 S-record byte extractor and flash page packer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one ASCII character of an S-record image per
//   request; character 10 ends a line. Each data byte of a type 2 record
//   comes out on the result channel with its 24-bit address, the page that
//   receives it, its offset in that page and flags for a page opening and
//   for page index saturation. Other characters give no result.
//   One character is taken every cycle while in_ready_o is high. A result
//   goes valid once the low digit of its byte has passed through the
//   parser register and then the packer result register.
//   Reset clears the line state, the page index, the fill count and the
//   next expected address (zero), and empties both registers.
//   When the receiver stalls, the held result stays put; one more decoded
//   byte waits in the parser register and in_ready_o drops only when that
//   register is also full, so characters that give no byte keep flowing
//   until the next byte is decoded.
// ----------------------------------------------------------------------------
module srecord_to_flash_pages
  import s2fp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  char_in_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [7:0]  data_byte_o,
  output logic [23:0] byte_address_o,
  output logic [9:0]  page_number_o,
  output logic [8:0]  page_offset_o,
  output logic        new_page_o,
  output logic        page_overflow_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  logic       ev_valid;
  logic       ev_ready;
  s2fp_byte_t ev;

  s2fp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_in_i  (char_in_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ev_valid_o (ev_valid),
    .ev_o       (ev),
    .ev_ready_i (ev_ready)
  );

  s2fp_packer u_packer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ev_valid_i      (ev_valid),
    .ev_i            (ev),
    .ev_ready_o      (ev_ready),
    .data_byte_o     (data_byte_o),
    .byte_address_o  (byte_address_o),
    .page_number_o   (page_number_o),
    .page_offset_o   (page_offset_o),
    .new_page_o      (new_page_o),
    .page_overflow_o (page_overflow_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the type 2 S-record page packer. Character lines
// (directed records, random records, contiguous runs across records, noise)
// go in through the request channel. A predictor tracks line parsing and
// page packing to check each result field by field.
// ----------------------------------------------------------------------------
module tb
  import s2fp_pkg::*;
;

  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned RANDOM_CHARS  = 1000;
  localparam int unsigned MAX_REPORTS   = 50;
  localparam logic [7:0]  CARRIAGE_RET  = 8'h0D;

  typedef struct packed {
    logic [7:0]  data;
    logic [23:0] addr;
    logic [9:0]  page;
    logic [8:0]  offset;
    logic        opened;
    logic        ovf;
  } flash_byte_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic [7:0]  char_in_i   = 8'd0;
  logic        in_valid_i  = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_o;
  logic [23:0] byte_address_o;
  logic [9:0]  page_number_o;
  logic [8:0]  page_offset_o;
  logic        new_page_o;
  logic        page_overflow_o;
  logic        out_valid_o;

  logic [7:0]  char_q[$];
  flash_byte_t flash_bytes_due[$];

  logic [3:0]  line_col;
  logic [3:0]  rec_kind;
  logic [7:0]  bytes_left;
  logic [23:0] rec_addr;
  logic [7:0]  byte_idx;
  logic [3:0]  hi_nib;
  bit          lo_phase;
  bit          in_data;
  logic [24:0] next_addr;
  int unsigned page_fill;
  int unsigned page_idx;

  int unsigned tx_gap       = 0;
  bit          tx_burst     = 1'b0;
  int unsigned rx_hold      = 0;
  bit          rx_burst     = 1'b0;
  int unsigned cycle_count  = 0;
  int unsigned chars_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned pages_opened = 0;
  int unsigned sat_bytes    = 0;
  int unsigned err_count    = 0;

  srecord_to_flash_pages u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .char_in_i       (char_in_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_o     (data_byte_o),
    .byte_address_o  (byte_address_o),
    .page_number_o   (page_number_o),
    .page_offset_o   (page_offset_o),
    .new_page_o      (new_page_o),
    .page_overflow_o (page_overflow_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    return 4'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return "0" + 8'(v);
    return (lower ? "a" : "A") + 8'(v) - 8'd10;
  endfunction

  task automatic predict_char(input logic [7:0] c);
    logic [3:0]  v;
    logic [23:0] a;
    flash_byte_t r;
    v = nibble_of(c);
    if (c == LINE_END) begin
      line_col   = '0;
      rec_kind   = '0;
      bytes_left = '0;
      rec_addr   = '0;
      byte_idx   = '0;
      hi_nib     = '0;
      lo_phase   = 1'b0;
      in_data    = 1'b0;
    end else if (!in_data) begin
      if (line_col == POS_KIND) begin
        rec_kind = v;
      end else if (line_col == POS_COUNT_HI) begin
        hi_nib = v;
      end else if (line_col == POS_COUNT_LO) begin
        bytes_left = ({hi_nib, v} >= COUNT_OVERHEAD) ? {hi_nib, v} - COUNT_OVERHEAD : 8'd0;
      end else if (line_col >= POS_ADDR_FIRST && line_col <= POS_ADDR_LAST) begin
        rec_addr = {rec_addr[19:0], v};
      end
      line_col = line_col + 4'd1;
      if (line_col >= POS_DATA_START) begin
        line_col = POS_DATA_START;
        in_data  = 1'b1;
        byte_idx = '0;
        lo_phase = 1'b0;
      end
    end else if (bytes_left != 8'd0) begin
      if (!lo_phase) begin
        hi_nib   = v;
        lo_phase = 1'b1;
      end else begin
        lo_phase = 1'b0;
        if (rec_kind == REC_KIND_S2) begin
          a        = rec_addr + 24'(byte_idx);
          r.opened = ({1'b0, a} != next_addr) || (page_fill >= PAGE_BYTES);
          r.ovf    = 1'b0;
          if (r.opened) begin
            pages_opened++;
            if (page_idx >= MAX_PAGES - 1) begin
              page_idx = MAX_PAGES - 1;
              r.ovf    = 1'b1;
              sat_bytes++;
            end else begin
              page_idx++;
            end
            next_addr = {1'b0, a};
            page_fill = 0;
          end
          r.data    = {hi_nib, v};
          r.addr    = a;
          r.page    = 10'(page_idx);
          r.offset  = 9'(page_fill);
          page_fill++;
          next_addr = next_addr + 25'd1;
          flash_bytes_due.push_back(r);
        end
        byte_idx   = byte_idx + 8'd1;
        bytes_left = bytes_left - 8'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned seen_v);
    if (want != seen_v) begin
      err_count++;
      if (err_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen_v);
      end
    end
  endtask

  task automatic push_text(input string s, input bit cr);
    for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
    if (cr) char_q.push_back(CARRIAGE_RET);
    char_q.push_back(LINE_END);
  endtask

  task automatic push_record(input logic [3:0] kind, input logic [7:0] count,
                             input logic [23:0] addr, input int n_data, input int cut,
                             input int garble);
    logic [7:0] line_q[$];
    logic [7:0] b;
    bit         lower;
    lower = ($urandom_range(0, 3) == 0);
    line_q.push_back(lower ? "s" : "S");
    line_q.push_back(hex_char(kind, lower));
    line_q.push_back(hex_char(count[7:4], lower));
    line_q.push_back(hex_char(count[3:0], lower));
    for (int i = 5; i >= 0; i--) line_q.push_back(hex_char(addr[i*4 +: 4], lower));
    for (int i = 0; i <= n_data; i++) begin
      b = 8'($urandom);
      line_q.push_back(hex_char(b[7:4], lower));
      line_q.push_back(hex_char(b[3:0], lower));
    end
    if ($urandom_range(0, 7) == 0) line_q.push_back(CARRIAGE_RET);
    if (cut >= 0) begin
      while (line_q.size() > cut) void'(line_q.pop_back());
    end
    foreach (line_q[i]) begin
      if ($urandom_range(0, 99) < garble) begin
        b = 8'($urandom);
        line_q[i] = (b == LINE_END) ? 8'h7E : b;
      end
      char_q.push_back(line_q[i]);
    end
    char_q.push_back(LINE_END);
  endtask

  task automatic push_noise();
    int unsigned k;
    k = $urandom_range(1, 20);
    repeat (k) char_q.push_back(8'($urandom_range(0, 255)));
    char_q.push_back(LINE_END);
  endtask

  task automatic wait_idle();
    while (char_q.size() != 0 || in_valid_i || flash_bytes_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap     <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_char(char_in_i);
        chars_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap != 0) begin
          in_valid_i <= 1'b0;
          tx_gap     <= tx_gap - 1;
        end else if (char_q.size() != 0) begin
          char_in_i  <= char_q.pop_front();
          in_valid_i <= 1'b1;
          tx_gap     <= tx_burst ? 0 : $urandom_range(0, 5);
          if ($urandom_range(0, 49) == 0) tx_burst <= !tx_burst;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    flash_byte_t due;
    bit          got;
    int unsigned gap;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_hold     <= 0;
    end else begin
      got = out_valid_o && out_ready_i;
      gap = rx_burst ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 99) == 0) rx_burst <= !rx_burst;
      if (got) begin
        results_seen++;
        if (flash_bytes_due.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: unexpected result, expected none, actual data 0x%0h addr 0x%0h",
                     $time, data_byte_o, byte_address_o);
          end
        end else begin
          due = flash_bytes_due.pop_front();
          check_field("data_byte", due.data, data_byte_o);
          check_field("byte_address", due.addr, byte_address_o);
          check_field("page_number", due.page, page_number_o);
          check_field("page_offset", due.offset, page_offset_o);
          check_field("new_page", due.opened, new_page_o);
          check_field("page_overflow", due.ovf, page_overflow_o);
        end
      end
      if (got && (results_seen == 40 || results_seen == 150)) begin
        rx_hold     <= LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (got && gap != 0) begin
        rx_hold     <= gap - 1;
        out_ready_i <= 1'b0;
      end else if (!got && rx_hold != 0) begin
        rx_hold     <= rx_hold - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("run stopped at cycle limit with %0d results outstanding",
               flash_bytes_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [23:0] run_addr;
    logic [23:0] addr;
    logic [3:0]  kind;
    int unsigned queued;
    int unsigned pick;
    int unsigned n;
    int unsigned q_len;
    bit          paused;

    line_col   = '0;
    rec_kind   = '0;
    bytes_left = '0;
    rec_addr   = '0;
    byte_idx   = '0;
    hi_nib     = '0;
    lo_phase   = 1'b0;
    in_data    = 1'b0;
    next_addr  = '0;
    page_fill  = 0;
    page_idx   = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_text("S2060000000000FFFA", 1'b0);
    push_text("s207000002abcdef00", 1'b0);
    char_q.push_back(8'h00);
    char_q.push_back(8'hFF);
    char_q.push_back(LINE_END);
    push_text("S2080001001234", 1'b0);
    push_text("S2030010005566", 1'b0);
    push_text("S10700200011223344", 1'b0);
    push_text("S2050Z00FF77", 1'b0);
    push_text("S207FFFFFE0102030400", 1'b1);
    push_text("S20", 1'b0);
    push_text("", 1'b0);
    push_text("S2050000200011223344", 1'b0);
    wait_idle();

    run_addr = 24'($urandom);
    queued   = 0;
    paused   = 1'b0;
    while (queued < RANDOM_CHARS) begin
      q_len = char_q.size();
      pick  = $urandom_range(0, 99);
      if (pick < 65) begin
        n    = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 251) : $urandom_range(0, 12);
        addr = ($urandom_range(0, 2) != 0) ? run_addr : 24'($urandom);
        push_record(REC_KIND_S2, 8'(n + 4), addr, n, -1, 0);
        run_addr = addr + 24'(n);
      end else if (pick < 75) begin
        kind = 4'($urandom_range(0, 15));
        if (kind == REC_KIND_S2) kind = kind + 4'd1;
        push_record(kind, 8'($urandom_range(0, 20)), 24'($urandom),
                    $urandom_range(0, 12), -1, 0);
      end else if (pick < 88) begin
        push_record(REC_KIND_S2, 8'($urandom_range(0, 255)), 24'($urandom),
                    $urandom_range(0, 20), $urandom_range(0, 30), 8);
      end else begin
        push_noise();
      end
      queued += char_q.size() - q_len;
      if (!paused && queued >= RANDOM_CHARS / 2) begin
        paused = 1'b1;
        wait_idle();
      end
    end
    wait_idle();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d characters; checked %0d data bytes over %0d page openings,",
             chars_taken, results_seen, pages_opened);
    $display("%0d of them at the saturated page index.", sat_bytes);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
